@@ hdl/fxalu_pkg.sv @@
// Shared types and constants for the Q24.8 fixed-point ALU.
// Depends on nothing; every other file refers to it by scoped names.
package fxalu_pkg;

  localparam int WORD_BITS = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef struct packed {
    logic [3:0]                  req_type;
    logic signed [WORD_BITS-1:0] operand_a;
    logic signed [WORD_BITS-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result_value;
    logic                        compare_true;
    logic                        divide_by_zero;
    logic                        overflow_flag;
  } rsp_t;

  // Control and finished results that ride alongside the divider chain.
  typedef struct packed {
    logic                 valid;
    op_t                  op;
    logic                 neg;
    logic [WORD_BITS-1:0] result;
    logic                 cmp;
    logic                 dbz;
    logic                 ovf;
  } side_t;

endpackage

@@ hdl/fxalu_cell.sv @@
// One restoring-division cell: produces one quotient bit per transaction.
// Depends on fxalu_pkg for the side-band struct.
module fxalu_cell #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  fxalu_pkg::side_t                            side_in,
  input  logic [fxalu_pkg::WORD_BITS-1:0]             rem_in,
  input  logic [fxalu_pkg::WORD_BITS+FRAC_BITS-1:0]   quo_in,
  input  logic [fxalu_pkg::WORD_BITS+FRAC_BITS-1:0]   num_in,
  input  logic [fxalu_pkg::WORD_BITS-1:0]             den_in,
  output fxalu_pkg::side_t                            side,
  output logic [fxalu_pkg::WORD_BITS-1:0]             rem,
  output logic [fxalu_pkg::WORD_BITS+FRAC_BITS-1:0]   quo,
  output logic [fxalu_pkg::WORD_BITS+FRAC_BITS-1:0]   num,
  output logic [fxalu_pkg::WORD_BITS-1:0]             den
);

  localparam int W = fxalu_pkg::WORD_BITS;
  localparam int N = W + FRAC_BITS;

  logic [W:0]   trial;
  logic         ge;
  logic [W-1:0] rem_next;

  assign trial    = {rem_in, num_in[N-1]};
  assign ge       = trial >= {1'b0, den_in};
  assign rem_next = ge ? W'(trial - {1'b0, den_in}) : trial[W-1:0];

  always_ff @(posedge clk) begin
    rem <= rem_next;
    quo <= {quo_in[N-2:0], ge};
    num <= {num_in[N-2:0], 1'b0};
    den <= den_in;
    if (rst) begin
      side <= '0;
    end else begin
      side <= side_in;
    end
  end

endmodule

@@ hdl/fixed_point_q24_8_alu.sv @@
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on fxalu_pkg and fxalu_cell.
//
// Usage:
//   Drive request and raise start; the transaction is taken at the clock
//   edge where start is high and busy is low. busy stays low: one
//   transaction may enter every cycle, back to back.
//   Each transaction returns exactly one response, shown for one cycle with
//   done high. The receiver cannot stall; responses leave in request order.
// Structure: an input register computes operand magnitudes, the wrapping
//   ops, comparisons and the multiply product; the multiply rounds and
//   saturates on its way into the chain. A row of WORD_BITS + FRAC_BITS
//   division cells each resolves one quotient bit, and every transaction
//   walks the whole row so that ordering and latency stay fixed. The output
//   register rounds and saturates the quotient.
// Throughput: one transaction per cycle.
// Reset: rst clears all valid bits; data in flight is dropped.
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  fxalu_pkg::req_t  request,
  output logic             done,
  output fxalu_pkg::rsp_t  response
);

  localparam int W = fxalu_pkg::WORD_BITS;
  localparam int N = W + FRAC_BITS;
  localparam logic [2*W:0] HALF =
      (FRAC_BITS > 0) ? ((2*W+1)'(1) << (FRAC_BITS - 1)) : '0;
  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MAX = {1'b1, {(W-1){1'b0}}};

  // ---------------- input stage ----------------
  logic [W-1:0] a_in, b_in, ma_in, mb_in, ka_in, kb_in, simple_in;
  logic         na_in, nb_in, cmp_in;
  fxalu_pkg::op_t op_in;

  assign busy  = 1'b0;
  assign op_in = fxalu_pkg::op_t'(request.req_type);
  assign a_in  = request.operand_a;
  assign b_in  = request.operand_b;
  assign na_in = a_in[W-1];
  assign nb_in = b_in[W-1];
  assign ma_in = na_in ? W'(-a_in) : a_in;
  assign mb_in = nb_in ? W'(-b_in) : b_in;
  // Flip the sign bit for an order-preserving unsigned compare.
  assign ka_in = a_in ^ NEG_MAX;
  assign kb_in = b_in ^ NEG_MAX;

  always_comb begin
    simple_in = '0;
    cmp_in    = 1'b0;
    case (op_in)
      fxalu_pkg::OP_ADD:      simple_in = W'(a_in + b_in);
      fxalu_pkg::OP_SUB:      simple_in = W'(a_in - b_in);
      fxalu_pkg::OP_GT:       cmp_in = ka_in > kb_in;
      fxalu_pkg::OP_LT:       cmp_in = ka_in < kb_in;
      fxalu_pkg::OP_GE:       cmp_in = ka_in >= kb_in;
      fxalu_pkg::OP_LE:       cmp_in = ka_in <= kb_in;
      fxalu_pkg::OP_EQ:       cmp_in = a_in == b_in;
      fxalu_pkg::OP_NE:       cmp_in = a_in != b_in;
      fxalu_pkg::OP_MIN:      simple_in = (ka_in < kb_in) ? a_in : b_in;
      fxalu_pkg::OP_MAX:      simple_in = (ka_in > kb_in) ? a_in : b_in;
      fxalu_pkg::OP_INC:      simple_in = W'(a_in + W'(1));
      fxalu_pkg::OP_DEC:      simple_in = W'(a_in - W'(1));
      fxalu_pkg::OP_FROM_INT: simple_in = a_in << FRAC_BITS;
      fxalu_pkg::OP_TO_INT:   simple_in = W'($signed(a_in) >>> FRAC_BITS);
      default:                simple_in = '0;
    endcase
    if (cmp_in) begin
      simple_in = W'(1);
    end
  end

  logic           s1_valid;
  fxalu_pkg::op_t s1_op;
  logic           s1_neg, s1_cmp, s1_bzero;
  logic [W-1:0]   s1_simple, s1_ma, s1_mb;
  logic [2*W-1:0] s1_prod;

  always_ff @(posedge clk) begin
    s1_op     <= op_in;
    s1_neg    <= na_in ^ nb_in;
    s1_cmp    <= cmp_in;
    s1_bzero  <= (b_in == '0);
    s1_simple <= simple_in;
    s1_ma     <= ma_in;
    s1_mb     <= mb_in;
    s1_prod   <= ma_in * mb_in;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  // ---------------- multiply finish, chain entry ----------------
  logic [2*W:0]     prod_rnd;
  logic [W-1:0]     mul_lim, mul_res;
  logic             mul_ovf;
  fxalu_pkg::side_t side0;

  assign prod_rnd = ({1'b0, s1_prod} + HALF) >> FRAC_BITS;
  assign mul_lim  = s1_neg ? NEG_MAX : POS_MAX;
  assign mul_ovf  = prod_rnd > {{(W+1){1'b0}}, mul_lim};
  assign mul_res  = mul_ovf ? mul_lim :
                    (s1_neg ? W'(-prod_rnd[W-1:0]) : prod_rnd[W-1:0]);

  always_comb begin
    side0        = '0;
    side0.valid  = s1_valid;
    side0.op     = s1_op;
    side0.neg    = s1_neg;
    side0.result = s1_simple;
    side0.cmp    = s1_cmp;
    if (s1_op == fxalu_pkg::OP_MUL) begin
      side0.result = mul_res;
      side0.ovf    = mul_ovf;
    end
    if (s1_op == fxalu_pkg::OP_DIV && s1_bzero) begin
      side0.dbz    = 1'b1;
    end
  end

  // ---------------- division chain ----------------
  fxalu_pkg::side_t side_c [N+1];
  logic [W-1:0]     rem_c  [N+1];
  logic [N-1:0]     quo_c  [N+1];
  logic [N-1:0]     num_c  [N+1];
  logic [W-1:0]     den_c  [N+1];

  assign side_c[0] = side0;
  assign rem_c[0]  = '0;
  assign quo_c[0]  = '0;
  assign num_c[0]  = N'(s1_ma) << FRAC_BITS;
  assign den_c[0]  = s1_mb;

  for (genvar i = 0; i < N; i++) begin : g_cell
    fxalu_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .side_in (side_c[i]),
      .rem_in  (rem_c[i]),
      .quo_in  (quo_c[i]),
      .num_in  (num_c[i]),
      .den_in  (den_c[i]),
      .side    (side_c[i+1]),
      .rem     (rem_c[i+1]),
      .quo     (quo_c[i+1]),
      .num     (num_c[i+1]),
      .den     (den_c[i+1])
    );
  end

  // ---------------- quotient rounding and output ----------------
  fxalu_pkg::side_t st;
  logic             rnd_up;
  logic [N:0]       q_rnd;
  logic [W-1:0]     div_lim;
  logic             div_ovf;
  fxalu_pkg::rsp_t  rsp_next;

  assign st      = side_c[N];
  // Round half away from zero: bump when twice the remainder reaches the divisor.
  assign rnd_up  = {rem_c[N], 1'b0} >= {1'b0, den_c[N]};
  assign q_rnd   = {1'b0, quo_c[N]} + (N+1)'(rnd_up);
  assign div_lim = st.neg ? NEG_MAX : POS_MAX;
  assign div_ovf = q_rnd > (N+1)'(div_lim);

  always_comb begin
    rsp_next                = '0;
    rsp_next.result_value   = st.result;
    rsp_next.compare_true   = st.cmp;
    rsp_next.overflow_flag  = st.ovf;
    if (st.op == fxalu_pkg::OP_DIV) begin
      if (st.dbz) begin
        rsp_next.result_value   = '0;
        rsp_next.divide_by_zero = 1'b1;
      end else if (div_ovf) begin
        rsp_next.result_value  = div_lim;
        rsp_next.overflow_flag = 1'b1;
      end else begin
        rsp_next.result_value = st.neg ? W'(-q_rnd[W-1:0]) : q_rnd[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    response <= rsp_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st.valid;
    end
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the Q24.8 fixed-point ALU (fixed_point_q24_8_alu).
// Depends on fxalu_pkg and the ALU RTL; predicts every response in-line and
// checks it against the DUT under random start gaps.
module testbench;

  localparam int FRAC = 8;
  localparam int LATENCY = fxalu_pkg::WORD_BITS + FRAC + 2;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  fxalu_pkg::req_t request;
  logic done;
  fxalu_pkg::rsp_t response;

  // Responses still owed by the DUT, oldest first.
  fxalu_pkg::rsp_t pending_rsp[$];
  int   errors;
  int   sent_cnt;
  int   checked_cnt;
  int   idle_pct;
  int   op_hits[16];

  fixed_point_q24_8_alu #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .response(response)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Saturate a wide magnitude with the given sign into the 32-bit range.
  function automatic logic [31:0] sat_sign(logic [127:0] mag, logic neg, output logic ovf);
    logic [127:0] limit;
    limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    ovf = (mag > limit);
    if (ovf) begin
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return neg ? 32'(-mag[31:0]) : mag[31:0];
  endfunction

  // Compute the expected response of one request.
  function automatic fxalu_pkg::rsp_t alu_predict(fxalu_pkg::req_t rq);
    fxalu_pkg::rsp_t r;
    logic [31:0]  a;
    logic [31:0]  b;
    logic         na;
    logic         nb;
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] wide;
    logic [127:0] quo;
    logic [127:0] rem;
    logic         ovf;
    a = rq.operand_a;
    b = rq.operand_b;
    na = a[31];
    nb = b[31];
    ma = na ? 128'(32'(-a)) : 128'(a);
    mb = nb ? 128'(32'(-b)) : 128'(b);
    r = '0;
    ovf = 1'b0;
    case (fxalu_pkg::op_t'(rq.req_type))
      fxalu_pkg::OP_ADD:      r.result_value = a + b;
      fxalu_pkg::OP_SUB:      r.result_value = a - b;
      fxalu_pkg::OP_MUL: begin
        wide = ((ma * mb) + (128'd1 << (FRAC - 1))) >> FRAC;
        r.result_value = sat_sign(wide, na ^ nb, ovf);
      end
      fxalu_pkg::OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          quo = (ma << FRAC) / mb;
          rem = (ma << FRAC) % mb;
          if (rem >= mb - rem) quo = quo + 1;
          r.result_value = sat_sign(quo, na ^ nb, ovf);
        end
      end
      fxalu_pkg::OP_GT:       r.compare_true = $signed(a) > $signed(b);
      fxalu_pkg::OP_LT:       r.compare_true = $signed(a) < $signed(b);
      fxalu_pkg::OP_GE:       r.compare_true = $signed(a) >= $signed(b);
      fxalu_pkg::OP_LE:       r.compare_true = $signed(a) <= $signed(b);
      fxalu_pkg::OP_EQ:       r.compare_true = a == b;
      fxalu_pkg::OP_NE:       r.compare_true = a != b;
      fxalu_pkg::OP_MIN:      r.result_value = ($signed(a) < $signed(b)) ? a : b;
      fxalu_pkg::OP_MAX:      r.result_value = ($signed(a) > $signed(b)) ? a : b;
      fxalu_pkg::OP_INC:      r.result_value = a + 32'd1;
      fxalu_pkg::OP_DEC:      r.result_value = a - 32'd1;
      fxalu_pkg::OP_FROM_INT: r.result_value = a << FRAC;
      default:                r.result_value = $signed(a) >>> FRAC;
    endcase
    // Comparisons report their outcome in the result word as well.
    if (rq.req_type inside {fxalu_pkg::OP_GT, fxalu_pkg::OP_LT, fxalu_pkg::OP_GE,
                            fxalu_pkg::OP_LE, fxalu_pkg::OP_EQ, fxalu_pkg::OP_NE})
      r.result_value = {31'd0, r.compare_true};
    r.overflow_flag = ovf;
    return r;
  endfunction

  // Send one transaction: drive at a falling edge, hold start until accepted.
  task automatic issue_req(fxalu_pkg::op_t op, logic [31:0] a, logic [31:0] b);
    fxalu_pkg::req_t rq;
    rq.req_type = op;
    rq.operand_a = a;
    rq.operand_b = b;
    @(negedge clk);
    // Random hold-off ahead of the transaction, per the current idle rate.
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    request <= rq;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(alu_predict(rq));
    op_hits[op]++;
    sent_cnt++;
  endtask

  // Check every response against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no transaction outstanding: %h", response);
        errors++;
      end else begin
        fxalu_pkg::rsp_t exp_r;
        exp_r = pending_rsp.pop_front();
        checked_cnt++;
        if (response.result_value !== exp_r.result_value) begin
          $error("result_value exp %h got %h", exp_r.result_value, response.result_value);
          errors++;
        end
        if (response.compare_true !== exp_r.compare_true) begin
          $error("compare_true exp %b got %b", exp_r.compare_true, response.compare_true);
          errors++;
        end
        if (response.divide_by_zero !== exp_r.divide_by_zero) begin
          $error("divide_by_zero exp %b got %b", exp_r.divide_by_zero,
                 response.divide_by_zero);
          errors++;
        end
        if (response.overflow_flag !== exp_r.overflow_flag) begin
          $error("overflow_flag exp %b got %b", exp_r.overflow_flag, response.overflow_flag);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000 | $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'($signed($urandom_range(2047)) - 1024);
      3: return 32'($signed($urandom_range(65535)) - 32768) << FRAC;
      default: return $urandom;
    endcase
  endfunction

  // Directed: every opcode on extreme operands, plus each named corner.
  task automatic test_corners();
    issue_req(fxalu_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
    issue_req(fxalu_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001);
    issue_req(fxalu_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FE80);
    issue_req(fxalu_pkg::OP_MUL, 32'h0000_0001, 32'h0000_0080);  // half rounds away from zero
    issue_req(fxalu_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
    issue_req(fxalu_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);  // saturate high
    issue_req(fxalu_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF);  // saturate low
    issue_req(fxalu_pkg::OP_MUL, 32'h8000_0000, 32'hFFFF_FF00);  // -min overflows
    issue_req(fxalu_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0000);  // divide by zero
    issue_req(fxalu_pkg::OP_DIV, 32'h0000_0001, 32'h0000_0200);  // exact half rounds up
    issue_req(fxalu_pkg::OP_DIV, 32'hFFFF_FD00, 32'h0000_0200);
    issue_req(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0001);  // saturate
    issue_req(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0100);  // exactly most negative
    issue_req(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FF00);
    issue_req(fxalu_pkg::OP_GT, 32'h8000_0000, 32'h7FFF_FFFF);
    issue_req(fxalu_pkg::OP_LT, 32'h8000_0000, 32'h7FFF_FFFF);
    issue_req(fxalu_pkg::OP_GE, 32'h1234_5678, 32'h1234_5678);
    issue_req(fxalu_pkg::OP_LE, 32'hFFFF_FFFF, 32'h0000_0000);
    issue_req(fxalu_pkg::OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_req(fxalu_pkg::OP_NE, 32'h0000_0000, 32'h0000_0000);
    issue_req(fxalu_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
    issue_req(fxalu_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
    issue_req(fxalu_pkg::OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    issue_req(fxalu_pkg::OP_DEC, 32'h8000_0000, 32'h0000_0000);
    issue_req(fxalu_pkg::OP_FROM_INT, 32'hFF80_0001, 32'h0);
    issue_req(fxalu_pkg::OP_TO_INT, 32'hFFFF_FFFF, 32'h0);  // floors toward minus infinity
  endtask

  // Random: all opcodes, operands biased toward edges, under one idle rate.
  task automatic test_random(int count, int pct);
    idle_pct = pct;
    repeat (count) begin
      issue_req(fxalu_pkg::op_t'($urandom_range(15)), rand_word(), rand_word());
    end
  endtask

  initial begin
    int guard;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    errors = 0;
    sent_cnt = 0;
    checked_cnt = 0;
    idle_pct = 0;
    foreach (op_hits[i]) op_hits[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corners();
    test_random(600, 11);
    test_random(600, 82);
    test_random(600, 0);
    @(negedge clk);
    start <= 1'b0;

    // Drain: wait on outstanding responses, then idle until the pipeline has emptied.
    guard = 0;
    while (pending_rsp.size() != 0 && guard < 10 * LATENCY) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d transactions never answered", pending_rsp.size());
      errors++;
    end

    $display("Sent %0d transactions across all 16 opcodes, %0d responses checked.",
             sent_cnt, checked_cnt);
    $display("Divides seen: %0d, multiplies seen: %0d.", op_hits[fxalu_pkg::OP_DIV],
             op_hits[fxalu_pkg::OP_MUL]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/fxalu_pkg.sv
hdl/fxalu_cell.sv
hdl/fixed_point_q24_8_alu.sv
tb/testbench.sv
